[rtl/sqtb_pkg.sv]
`default_nettype none
package sqtb_pkg;

  localparam int unsigned CoordBitsDef   = 16;
  localparam int unsigned TextureBitsDef = 16;
  localparam int unsigned AngleBitsDef   = 16;
  localparam int unsigned CordicSteps    = 24;

  localparam logic KIND_DRAW  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic REC_VERTEX = 1'b0;
  localparam logic REC_CLOSE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] texture_id;
    logic [31:0] color;
    logic [31:0] size_xy;
    logic [63:0] tex_rect;
    logic [31:0] origin_xy;
    logic [31:0] position_xy;
    logic [31:0] scale_xy;
    logic [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic               record_type;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [15:0]        tex_handle;
    logic [15:0]        batch_vertices;
    logic               last;
  } out_item_t;

  // Arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/sqtb_cordic.sv]
`default_nettype none
module sqtb_cordic import sqtb_pkg::*; #(
  parameter int unsigned AngleBits = AngleBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [15:0]              angle_i,
  output logic                          done_o,
  output logic signed [15:0]            cos_o,
  output logic signed [15:0]            sin_o
);

  // Keep only the top angle bits of the turn
  localparam int unsigned AngleKeep = (AngleBits < 16) ? AngleBits : 16;
  localparam logic [15:0] AngleMask = 16'(~((32'd1 << (16 - AngleKeep)) - 32'd1));

  logic               busy_q;
  logic [4:0]         step_q;
  logic               flip_q;
  logic signed [33:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic               done_q;
  logic signed [15:0] cos_q, sin_q;

  logic [31:0] th;
  logic [31:0] th_f;
  logic        flip_d;
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] x_n, y_n;

  // Round Q30 to Q14 half up, clamp to unit
  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v,
                                                input logic neg);
    logic signed [33:0] r;
    logic signed [15:0] c;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) c = 16'sd16384;
    else if (r < -34'sd16384) c = -16'sd16384;
    else c = r[15:0];
    return neg ? -c : c;
  endfunction

  always_comb begin
    th = {angle_i & AngleMask, 16'h0000};
    flip_d = ((th - 32'h4000_0000) < 32'h8000_0000);
    th_f = flip_d ? (th - 32'h8000_0000) : th;
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = {4'd0, atan_turn(step_q)};
    x_n = (z_q >= 0) ? x_q - ys : x_q + ys;
    y_n = (z_q >= 0) ? y_q + xs : y_q - xs;
  end

  // Iterate one rotation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      cos_q  <= '0;
      sin_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
        flip_q <= flip_d;
        x_q <= 34'sd652032874;
        y_q <= '0;
        z_q <= {{2{th_f[31]}}, th_f};
      end else if (busy_q) begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= (z_q >= 0) ? z_q - at : z_q + at;
        if (step_q == 5'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          cos_q  <= to_q14(x_n, flip_q);
          sin_q  <= to_q14(y_n, flip_q);
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule
`default_nettype wire

[rtl/sprite_quad_transform_batcher_unit.sv]
`default_nettype none
// Sprite quad transform batcher.
// Input channel in_valid_i/in_stall_o carries one in_item_t per transfer:
// a sprite draw or a flush of the open batch. Output channel
// out_valid_o/out_stall_i carries out_item_t records: an optional
// batch-closed record, then four corner vertices for a draw; last marks
// the final record of each input item. A flush of an empty batch gives
// no record.
// A draw runs the CORDIC (start, 24 iterations, handoff), then for each
// corner the shared multiplier (four products of two passes each, then
// the output load). The next draw is taken once the fourth vertex is
// loaded. A flush ends in the idle state, or goes through the close
// state when it closes a batch.
// The input is stalled while an item is in work. When the receiver
// stalls, the record holds in the output register and the sequencer
// waits until the register is free. Reset clears the open batch (no
// texture, count zero) and empties the output register.
module sprite_quad_transform_batcher_unit import sqtb_pkg::*; #(
  parameter int unsigned TextureBits = TextureBitsDef,
  parameter int unsigned AngleBits   = AngleBitsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  // Texture handles compare on their low bits only
  localparam int unsigned TexKeep = (TextureBits < 16) ? TextureBits : 16;
  localparam logic [15:0] TexMask = 16'((32'd1 << TexKeep) - 32'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_CLOSE, S_TRIG, S_MUL, S_ACC, S_EMIT
  } state_e;

  state_e      state_q;
  in_item_t    item_q;
  logic [15:0] open_tex_q;
  logic        open_valid_q;
  logic [15:0] open_count_q;
  logic [1:0]  corner_q;
  logic [1:0]  phase_q;
  logic signed [15:0] cos_q, sin_q;
  logic signed [49:0] ax_q, ay_q;
  logic signed [31:0] prod_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        cordic_start;
  logic        cordic_done;
  logic signed [15:0] c_cos, c_sin;
  logic [15:0] tex_in;
  logic        out_free;
  logic        out_load;

  // Corner geometry and the shared multiplier
  logic signed [17:0] dx, dy;
  logic signed [15:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [15:0] trig_a;
  logic signed [31:0] mult_a;
  logic signed [17:0] mult_b;
  logic signed [49:0] mult_p;
  logic [15:0] w, h, cx, cy;
  logic signed [49:0] rx, ry;
  logic signed [34:0] fx, fy;
  logic [15:0] cu, cv;
  out_item_t   close_rec;
  out_item_t   vert_rec;

  sqtb_cordic #(.AngleBits(AngleBits)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (item_q.angle),
    .done_o  (cordic_done),
    .cos_o   (c_cos),
    .sin_o   (c_sin)
  );

  assign tex_in       = in_data_i.texture_id & TexMask;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_load     = out_free && ((state_q == S_CLOSE) || (state_q == S_EMIT));
  assign cordic_start = (state_q == S_TRIG) && (phase_q == 2'd0);

  function automatic logic [15:0] sat_c(input logic signed [34:0] v);
    logic signed [34:0] hi, lo;
    logic signed [15:0] r;
    hi = 35'sd1 <<< (CoordBitsDef - 1);
    hi = hi - 35'sd1;
    lo = -hi - 35'sd1;
    if (v > hi) r = 16'(hi);
    else if (v < lo) r = 16'(lo);
    else r = v[15:0];
    return r;
  endfunction

  always_comb begin
    w  = item_q.size_xy[31:16];
    h  = item_q.size_xy[15:0];
    cx = (corner_q == 2'd1 || corner_q == 2'd2) ? w : 16'd0;
    cy = (corner_q == 2'd2 || corner_q == 2'd3) ? h : 16'd0;
    dx = $signed({2'b00, cx}) - 18'(signed'(item_q.origin_xy[31:16]));
    dy = $signed({2'b00, cy}) - 18'(signed'(item_q.origin_xy[15:0]));
    cu = (corner_q == 2'd1 || corner_q == 2'd2) ? item_q.tex_rect[31:16]
                                                : item_q.tex_rect[63:48];
    cv = (corner_q == 2'd2 || corner_q == 2'd3) ? item_q.tex_rect[15:0]
                                                : item_q.tex_rect[47:32];
    // phase 0: sx*cos*dx  1: sy*sin*dy  2: sx*sin*dx  3: sy*cos*dy
    case (phase_q)
      2'd0: begin mul_a = signed'(item_q.scale_xy[31:16]); trig_a = cos_q; end
      2'd1: begin mul_a = signed'(item_q.scale_xy[15:0]);  trig_a = sin_q; end
      2'd2: begin mul_a = signed'(item_q.scale_xy[31:16]); trig_a = sin_q; end
      default: begin mul_a = signed'(item_q.scale_xy[15:0]); trig_a = cos_q; end
    endcase
    mul_b = phase_q[0] ? dy : dx;
    // first pass scale times trig, second pass that product times delta
    mult_a = (state_q == S_MUL) ? 32'(mul_a) : prod_q;
    mult_b = (state_q == S_MUL) ? 18'(trig_a) : mul_b;
    mult_p = 50'(mult_a) * 50'(mult_b);
    rx = (ax_q + 50'sd33554432) >>> 26;
    ry = (ay_q + 50'sd33554432) >>> 26;
    fx = 35'(rx) + 35'(signed'(item_q.position_xy[31:16]));
    fy = 35'(ry) + 35'(signed'(item_q.position_xy[15:0]));
  end

  // Build the batch-closed and vertex records
  always_comb begin
    close_rec = '0;
    close_rec.record_type    = REC_CLOSE;
    close_rec.tex_handle     = open_tex_q;
    close_rec.batch_vertices = open_count_q;
    close_rec.last           = (item_q.kind == KIND_FLUSH);
    vert_rec = '0;
    vert_rec.record_type  = REC_VERTEX;
    vert_rec.out_x        = sat_c(fx);
    vert_rec.out_y        = sat_c(fy);
    vert_rec.tex_u        = cu;
    vert_rec.tex_v        = cv;
    vert_rec.vertex_color = item_q.color;
    vert_rec.tex_handle   = open_tex_q;
    vert_rec.last         = (corner_q == 2'd3);
  end

  // Sequencer with output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      open_tex_q   <= '0;
      open_valid_q <= 1'b0;
      open_count_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      corner_q     <= '0;
      phase_q      <= '0;
      cos_q        <= '0;
      sin_q        <= '0;
      ax_q         <= '0;
      ay_q         <= '0;
      prod_q       <= '0;
    end else begin
      // Load a record, or drop the one just taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= (state_q == S_CLOSE) ? close_rec : vert_rec;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            phase_q <= '0;
            if (in_data_i.kind == KIND_FLUSH) begin
              open_valid_q <= 1'b0;
              if (open_count_q != 16'd0) state_q <= S_CLOSE;
              else open_tex_q <= '0;
            end else if (!open_valid_q || open_tex_q != tex_in) begin
              if (open_count_q != 16'd0) state_q <= S_CLOSE;
              else begin
                state_q      <= S_TRIG;
                open_tex_q   <= tex_in;
                open_valid_q <= 1'b1;
                open_count_q <= 16'd4;
              end
            end else begin
              state_q      <= S_TRIG;
              open_count_q <= (open_count_q > 16'd65531) ? 16'hFFFF
                                                         : open_count_q + 16'd4;
            end
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            if (item_q.kind == KIND_FLUSH) begin
              open_tex_q   <= '0;
              open_count_q <= '0;
              state_q      <= S_IDLE;
            end else begin
              open_tex_q   <= item_q.texture_id & TexMask;
              open_valid_q <= 1'b1;
              open_count_q <= 16'd4;
              state_q      <= S_TRIG;
              phase_q      <= '0;
            end
          end
        end
        S_TRIG: begin
          if (cordic_done) begin
            cos_q    <= c_cos;
            sin_q    <= c_sin;
            corner_q <= '0;
            phase_q  <= '0;
            ax_q     <= '0;
            ay_q     <= '0;
            state_q  <= S_MUL;
          end else begin
            phase_q <= 2'd1;
          end
        end
        S_MUL: begin
          prod_q  <= 32'(mult_p);
          state_q <= S_ACC;
        end
        S_ACC: begin
          // accumulate the term exactly
          case (phase_q)
            2'd0:    ax_q <= ax_q + mult_p;
            2'd1:    ax_q <= ax_q - mult_p;
            default: ay_q <= ay_q + mult_p;
          endcase
          if (phase_q == 2'd3) state_q <= S_EMIT;
          else begin
            phase_q <= phase_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (corner_q == 2'd3) state_q <= S_IDLE;
            else begin
              corner_q <= corner_q + 2'd1;
              phase_q  <= '0;
              ax_q     <= '0;
              ay_q     <= '0;
              state_q  <= S_MUL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_close_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_type == REC_CLOSE
      |-> out_data_o.batch_vertices != 16'd0) else $error("empty batch closed");
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> in_stall_o) else $error("input open in work");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("record dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("record changed");
`endif

endmodule
`default_nettype wire

[verif/tb_sprite_quad_transform_batcher_unit.sv]
`timescale 1ns / 100ps
module tb_sprite_quad_transform_batcher_unit;
  import sqtb_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  sprite_quad_transform_batcher_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  in_item_t  sprite_queue[$];
  out_item_t vertex_queue[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          stimulus_done;
  bit          in_accepted;

  // Shadow of the open batch
  logic [15:0] batch_texture;
  logic        batch_open;
  logic [15:0] batch_count;

  // Arctangent table in units of 2^-32 turn
  longint atan_lut[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint floor_div2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_q14(longint v);
    longint r;
    r = floor_div2(v + 32768, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // Rotate a unit vector by the angle with an integer CORDIC
  task automatic rotate_angle(input logic [31:0] th_in, output longint co, output longint si);
    logic [31:0] th;
    bit          flip;
    longint      x, y, z, xs, ys;
    th = th_in;
    flip = 0;
    x = 652032874;
    y = 0;
    if ((th - 32'h4000_0000) < 32'h8000_0000) begin
      th = th - 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(th));
    for (int i = 0; i < 24; i++) begin
      xs = floor_div2(x, i);
      ys = floor_div2(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_lut[i];
      end else begin
        x += ys; y -= xs; z += atan_lut[i];
      end
    end
    co = round_q14(x);
    si = round_q14(y);
    if (flip) begin
      co = -co;
      si = -si;
    end
  endtask

  function automatic logic [15:0] clamp_coord(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Append the records one sprite or flush should produce
  task automatic predict_vertices(input in_item_t it);
    out_item_t   rec;
    longint      co, si, w, h, ox, oy, px, py, sx, sy, dx, dy, ax, ay;
    longint      cx[4], cy[4];
    logic [15:0] cu[4], cv[4];
    if (it.kind == KIND_FLUSH) begin
      if (batch_count != 0) begin
        rec = '0;
        rec.record_type = REC_CLOSE;
        rec.tex_handle = batch_texture;
        rec.batch_vertices = batch_count;
        rec.last = 1'b1;
        vertex_queue.insert(vertex_queue.size(), rec);
      end
      batch_count = 0;
      batch_texture = 0;
      batch_open = 0;
      return;
    end
    if (!batch_open || batch_texture != it.texture_id) begin
      if (batch_count != 0) begin
        rec = '0;
        rec.record_type = REC_CLOSE;
        rec.tex_handle = batch_texture;
        rec.batch_vertices = batch_count;
        vertex_queue.insert(vertex_queue.size(), rec);
      end
      batch_count = 0;
      batch_texture = it.texture_id;
      batch_open = 1;
    end
    batch_count = (batch_count > 16'd65531) ? 16'hFFFF : batch_count + 16'd4;
    rotate_angle({it.angle, 16'h0}, co, si);
    w  = it.size_xy[31:16];
    h  = it.size_xy[15:0];
    ox = longint'($signed(it.origin_xy[31:16]));
    oy = longint'($signed(it.origin_xy[15:0]));
    px = longint'($signed(it.position_xy[31:16]));
    py = longint'($signed(it.position_xy[15:0]));
    sx = longint'($signed(it.scale_xy[31:16]));
    sy = longint'($signed(it.scale_xy[15:0]));
    cx = '{0, w, w, 0};
    cy = '{0, 0, h, h};
    cu = '{it.tex_rect[63:48], it.tex_rect[31:16], it.tex_rect[31:16], it.tex_rect[63:48]};
    cv = '{it.tex_rect[47:32], it.tex_rect[47:32], it.tex_rect[15:0], it.tex_rect[15:0]};
    for (int k = 0; k < 4; k++) begin
      dx = cx[k] - ox;
      dy = cy[k] - oy;
      ax = sx * co * dx - sy * si * dy;
      ay = sx * si * dx + sy * co * dy;
      rec = '0;
      rec.record_type = REC_VERTEX;
      rec.out_x = clamp_coord(floor_div2(ax + (64'sd1 <<< 25), 26) + px);
      rec.out_y = clamp_coord(floor_div2(ay + (64'sd1 <<< 25), 26) + py);
      rec.tex_u = cu[k];
      rec.tex_v = cv[k];
      rec.vertex_color = it.color;
      rec.tex_handle = it.texture_id;
      rec.last = (k == 3);
      vertex_queue.insert(vertex_queue.size(), rec);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t random_sprite(logic [15:0] tex);
    in_item_t it;
    it.kind        = KIND_DRAW;
    it.texture_id  = tex;
    it.color       = $urandom;
    it.tex_rect    = {$urandom, $urandom};
    it.angle       = 16'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        it.size_xy     = $urandom;
        it.origin_xy   = $urandom;
        it.position_xy = $urandom;
        it.scale_xy    = $urandom;
      end
      default: begin
        it.size_xy     = {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048))};
        it.origin_xy   = {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024))};
        it.position_xy = {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000))};
        it.scale_xy    = {16'($urandom_range(0, 8192) - 4096),
                          16'($urandom_range(0, 8192) - 4096)};
      end
    endcase
    return it;
  endfunction

  // Fill the sprite queue: directed corners first, then batched random runs
  initial begin
    in_item_t    it;
    logic [15:0] tex;
    logic [15:0] angles[8];
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
               16'h2000, 16'h3FFF, 16'hC001, 16'hFFFF};
    stimulus_done = 0;
    it = '0;
    sprite_queue.insert(sprite_queue.size(), it);
    it.kind = KIND_FLUSH;
    sprite_queue.insert(sprite_queue.size(), it);
    sprite_queue.insert(sprite_queue.size(), it);
    for (int i = 0; i < 8; i++) begin
      it = random_sprite(16'h0005);
      it.angle = angles[i];
      sprite_queue.insert(sprite_queue.size(), it);
    end
    it = '1;
    it.kind = KIND_DRAW;
    sprite_queue.insert(sprite_queue.size(), it);
    it.scale_xy = 32'h8000_8000;
    it.size_xy = 32'hFFFF_FFFF;
    it.origin_xy = 32'h8000_8000;
    it.position_xy = 32'h7FFF_7FFF;
    sprite_queue.insert(sprite_queue.size(), it);
    it.position_xy = 32'h8000_8000;
    it.origin_xy = 32'h7FFF_7FFF;
    it.texture_id = 16'h0000;
    sprite_queue.insert(sprite_queue.size(), it);
    it = '0;
    it.kind = KIND_FLUSH;
    it.texture_id = 16'hFFFF;
    sprite_queue.insert(sprite_queue.size(), it);
    tex = 16'h0003;
    for (int n = 0; n < 260; n++) begin
      case ($urandom_range(0, 19))
        0: begin
          it = random_sprite(16'($urandom));
          it.kind = KIND_FLUSH;
          sprite_queue.insert(sprite_queue.size(), it);
        end
        1, 2: begin
          tex = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 7));
          sprite_queue.insert(sprite_queue.size(), random_sprite(tex));
        end
        default: sprite_queue.insert(sprite_queue.size(), random_sprite(tex));
      endcase
    end
    stimulus_done = 1;
  end

  // Reset once, drive inputs at the falling edge
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  int unsigned send_gap;
  int unsigned stall_left;

  // Driver: hold the payload while stalled, insert random gaps between transfers
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_accepted) begin
        send_gap = pick_gap();
        if (send_gap == 0 && sprite_queue.size() > 0) begin
          in_data_i <= sprite_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sprite_queue.size() > 0) begin
          in_data_i <= sprite_queue.pop_front();
          in_valid_i <= 1'b1;
        end
      end
      // Stall the output in random bursts
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left > 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      batch_texture = 0;
      batch_open = 0;
      batch_count = 0;
      in_accepted = 1'b0;
      idle_cycles <= 0;
    end else begin
      in_accepted = in_valid_i && !in_stall_o;
      if (in_accepted) predict_vertices(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (vertex_queue.size() == 0) begin
          report_mismatch("unexpected record", 64'(out_data_o.record_type), 64'd0);
        end else begin
          want = vertex_queue.pop_front();
          if (out_data_o.record_type !== want.record_type)
            report_mismatch("record_type", 64'(out_data_o.record_type), 64'(want.record_type));
          if (out_data_o.out_x !== want.out_x)
            report_mismatch("out_x", 64'(out_data_o.out_x), 64'(want.out_x));
          if (out_data_o.out_y !== want.out_y)
            report_mismatch("out_y", 64'(out_data_o.out_y), 64'(want.out_y));
          if (out_data_o.tex_u !== want.tex_u)
            report_mismatch("tex_u", 64'(out_data_o.tex_u), 64'(want.tex_u));
          if (out_data_o.tex_v !== want.tex_v)
            report_mismatch("tex_v", 64'(out_data_o.tex_v), 64'(want.tex_v));
          if (out_data_o.vertex_color !== want.vertex_color)
            report_mismatch("vertex_color", 64'(out_data_o.vertex_color),
                            64'(want.vertex_color));
          if (out_data_o.tex_handle !== want.tex_handle)
            report_mismatch("tex_handle", 64'(out_data_o.tex_handle), 64'(want.tex_handle));
          if (out_data_o.batch_vertices !== want.batch_vertices)
            report_mismatch("batch_vertices", 64'(out_data_o.batch_vertices),
                            64'(want.batch_vertices));
          if (out_data_o.last !== want.last)
            report_mismatch("last", 64'(out_data_o.last), 64'(want.last));
        end
      end
      if (in_accepted || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Finish after drain, or on watchdog timeout
  initial begin
    mismatch_count = 0;
    send_gap = 0;
    stall_left = 0;
    @(posedge rst_ni);
    while (!(stimulus_done && sprite_queue.size() == 0 && !in_valid_i &&
             vertex_queue.size() == 0) && idle_cycles < IdleLimit)
      @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("tb_sprite_quad_transform_batcher_unit: errors");
    end else begin
      repeat (DrainCycles) @(posedge clk_i);
      if (mismatch_count == 0 && vertex_queue.size() == 0)
        $display("tb_sprite_quad_transform_batcher_unit: clean");
      else
        $display("tb_sprite_quad_transform_batcher_unit: errors");
    end
    $finish;
  end

endmodule
